// File: sv/bam_pkg.sv
package bam_pkg;

   localparam int PIX_W     = 8;
   localparam int MEAN_W    = 8;
   localparam int POS_W     = 12;
   localparam int CFG_W     = 13;
   localparam int DIM_W     = 14;
   localparam int SQREG_W   = 7;
   localparam int IDX_W     = 2;
   localparam int ITER_W    = 3;
   localparam int HEIGHT_LIMIT = 4096;

   localparam logic [IDX_W-1:0] REG_SQUARE_SIZE  = 2'd0;
   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

   typedef struct packed {
      logic accept;
      logic write_back;
      logic div_step;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic block_done;
      logic div_last;
      logic out_free;
   } ctl_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUM  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_HOLD = 4'b1000
   } ctl_state_type;

endpackage

// File: sv/bam_if.sv
interface bam_pixel_if;
   import bam_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_ch0;
   logic [PIX_W-1:0] pixel_ch1;
   logic [PIX_W-1:0] pixel_ch2;
   modport source (output valid, pixel_ch0, pixel_ch1, pixel_ch2, input ready);
   modport sink   (input valid, pixel_ch0, pixel_ch1, pixel_ch2, output ready);
endinterface

interface bam_block_if;
   import bam_pkg::*;
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  block_row;
   logic [POS_W-1:0]  block_col;
   logic [MEAN_W-1:0] mean_ch0;
   logic [MEAN_W-1:0] mean_ch1;
   logic [MEAN_W-1:0] mean_ch2;
   logic              frame_done;
   modport source (output valid, block_row, block_col, mean_ch0, mean_ch1, mean_ch2,
                   frame_done, input ready);
   modport sink   (input valid, block_row, block_col, mean_ch0, mean_ch1, mean_ch2,
                   frame_done, output ready);
endinterface

// File: sv/block_average_mosaic.sv
// Channel   Dir  Handshake     Payload
// req_if    in   valid/ready   pixel_ch0, pixel_ch1, pixel_ch2 (8b each)
// rsp_if    out  valid/ready   block_row, block_col, mean_ch0..2, frame_done
// csr_*     in   write enable  csr_index (2b), csr_wdata (13b)
//
// Each pixel transaction reads its block column's accumulator from the
// single-port memory, then adds the pixel and writes the sum back.
// A pixel that closes a block then runs the shared restoring division
// (one mean bit per cycle for all three channels) and loads the result
// register. A full result register holds the controller before that
// load only. Reset is synchronous; the accumulator memory needs no clearing,
// since the first pixel of each block overwrites its entry.
module block_average_mosaic #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_SQUARE = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [bam_pkg::IDX_W-1:0]  csr_index,
   input  logic [bam_pkg::CFG_W-1:0]  csr_wdata,
   bam_pixel_if.sink                  req_if,
   bam_block_if.source                rsp_if
);
   import bam_pkg::*;

   ctl_cmd_type cmd;
   ctl_sts_type sts;

   // sequence each transaction: read, accumulate, divide, present
   bam_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // scan counters, accumulator memory, divider and result register
   bam_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_SQUARE (MAX_SQUARE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .pixel_ch0  (req_if.pixel_ch0),
      .pixel_ch1  (req_if.pixel_ch1),
      .pixel_ch2  (req_if.pixel_ch2),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .block_row  (rsp_if.block_row),
      .block_col  (rsp_if.block_col),
      .mean_ch0   (rsp_if.mean_ch0),
      .mean_ch1   (rsp_if.mean_ch1),
      .mean_ch2   (rsp_if.mean_ch2),
      .frame_done (rsp_if.frame_done),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// File: sv/bam_ctrl.sv
module bam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  bam_pkg::ctl_sts_type  sts,
   output bam_pkg::ctl_cmd_type  cmd
);
   import bam_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.write_back = 1'b1;
            state_in = sts.block_done ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            cmd.out_load = sts.out_free;
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: sv/bam_datapath.sv
module bam_datapath #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_SQUARE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [bam_pkg::IDX_W-1:0]   csr_index,
   input  logic [bam_pkg::CFG_W-1:0]   csr_wdata,
   input  logic [bam_pkg::PIX_W-1:0]   pixel_ch0,
   input  logic [bam_pkg::PIX_W-1:0]   pixel_ch1,
   input  logic [bam_pkg::PIX_W-1:0]   pixel_ch2,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [bam_pkg::POS_W-1:0]   block_row,
   output logic [bam_pkg::POS_W-1:0]   block_col,
   output logic [bam_pkg::MEAN_W-1:0]  mean_ch0,
   output logic [bam_pkg::MEAN_W-1:0]  mean_ch1,
   output logic [bam_pkg::MEAN_W-1:0]  mean_ch2,
   output logic                        frame_done,
   input  bam_pkg::ctl_cmd_type        cmd,
   output bam_pkg::ctl_sts_type        sts
);
   import bam_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int SQW  = (MAX_SQUARE > 2) ? $clog2(MAX_SQUARE) : 1;
   localparam int SUMW = PIX_W + 2 * SQW;
   localparam int CNTW = 2 * SQW + 1;

   // configuration
   logic [SQREG_W-1:0] sq_reg_ff;
   logic [CFG_W-1:0]   width_reg_ff, height_reg_ff;
   logic [DIM_W-1:0]   sq, w, h;

   // scan position
   logic [CW-1:0]    col_pos_ff, bci_ff;
   logic [POS_W-1:0] row_pos_ff, band_ff;
   logic [SQW-1:0]   cib_ff, rib_ff;
   logic             last_col, last_row, blk_right, blk_bottom;

   // captured transaction
   logic [PIX_W-1:0]  px_ff [3];
   logic [CW-1:0]     slot_ff;
   logic              first_ff, done_ff, frame_ff;
   logic [POS_W-1:0]  brow_ff, bcol_ff;
   logic [CNTW-1:0]   count_ff;

   // accumulator memory
   logic [3*SUMW-1:0] mem [MAX_WIDTH];
   logic [3*SUMW-1:0] rd_ff, wr_data;
   logic [SUMW-1:0]   new_sum [3];

   // divider
   logic [SUMW-1:0]   rem_ff [3];
   logic [MEAN_W-1:0] quo_ff [3];
   logic [ITER_W-1:0] iter_ff;
   logic [SUMW:0]     dvs;

   logic [MEAN_W-1:0] mean_ff [3];
   logic              out_valid_ff;

   always_comb begin
      if (sq_reg_ff == '0)                         sq = DIM_W'(1);
      else if (DIM_W'(sq_reg_ff) > DIM_W'(MAX_SQUARE)) sq = DIM_W'(MAX_SQUARE);
      else                                         sq = DIM_W'(sq_reg_ff);
      if (width_reg_ff == '0)                          w = DIM_W'(1);
      else if (DIM_W'(width_reg_ff) > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
      else                                             w = DIM_W'(width_reg_ff);
      if (height_reg_ff == '0)                            h = DIM_W'(1);
      else if (DIM_W'(height_reg_ff) > DIM_W'(HEIGHT_LIMIT)) h = DIM_W'(HEIGHT_LIMIT);
      else                                                h = DIM_W'(height_reg_ff);
   end

   assign last_col   = DIM_W'(col_pos_ff) >= w - DIM_W'(1);
   assign last_row   = DIM_W'(row_pos_ff) >= h - DIM_W'(1);
   assign blk_right  = last_col || (DIM_W'(cib_ff) >= sq - DIM_W'(1));
   assign blk_bottom = last_row || (DIM_W'(rib_ff) >= sq - DIM_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_reg_ff     <= SQREG_W'(8);
         width_reg_ff  <= CFG_W'(640);
         height_reg_ff <= CFG_W'(480);
         col_pos_ff    <= '0;
         row_pos_ff    <= '0;
         cib_ff        <= '0;
         rib_ff        <= '0;
         bci_ff        <= '0;
         band_ff       <= '0;
      end else if (csr_we && (csr_index == REG_SQUARE_SIZE || csr_index == REG_IMAGE_WIDTH
                              || csr_index == REG_IMAGE_HEIGHT)) begin
         case (csr_index)
            REG_SQUARE_SIZE:  sq_reg_ff     <= csr_wdata[SQREG_W-1:0];
            REG_IMAGE_WIDTH:  width_reg_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT: height_reg_ff <= csr_wdata;
            default: ;
         endcase
         // restart the frame scan
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
         bci_ff     <= '0;
         band_ff    <= '0;
      end else if (cmd.accept) begin
         if (last_col) begin
            col_pos_ff <= '0;
            cib_ff     <= '0;
            bci_ff     <= '0;
            if (last_row) begin
               row_pos_ff <= '0;
               rib_ff     <= '0;
               band_ff    <= '0;
            end else begin
               row_pos_ff <= row_pos_ff + POS_W'(1);
               if (DIM_W'(rib_ff) >= sq - DIM_W'(1)) begin
                  rib_ff  <= '0;
                  band_ff <= band_ff + POS_W'(1);
               end else begin
                  rib_ff <= rib_ff + SQW'(1);
               end
            end
         end else begin
            col_pos_ff <= col_pos_ff + CW'(1);
            if (DIM_W'(cib_ff) >= sq - DIM_W'(1)) begin
               cib_ff <= '0;
               bci_ff <= bci_ff + CW'(1);
            end else begin
               cib_ff <= cib_ff + SQW'(1);
            end
         end
      end
   end

   // capture the transaction and its block flags
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff[0] <= pixel_ch0;
         px_ff[1] <= pixel_ch1;
         px_ff[2] <= pixel_ch2;
         slot_ff  <= bci_ff;
         first_ff <= (rib_ff == '0) && (cib_ff == '0);
         done_ff  <= blk_right && blk_bottom;
         frame_ff <= last_col && last_row;
         brow_ff  <= band_ff;
         bcol_ff  <= POS_W'(bci_ff);
         count_ff <= CNTW'((SQW+1)'(cib_ff) + (SQW+1)'(1))
                   * CNTW'((SQW+1)'(rib_ff) + (SQW+1)'(1));
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         new_sum[c] = first_ff ? SUMW'(px_ff[c])
                               : rd_ff[c*SUMW +: SUMW] + SUMW'(px_ff[c]);
      end
      wr_data = {new_sum[2], new_sum[1], new_sum[0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) rd_ff <= mem[bci_ff];
      if (cmd.write_back) mem[slot_ff] <= wr_data;
   end

   // restoring division, one quotient bit per cycle for all channels
   assign dvs = (SUMW+1)'(count_ff) << iter_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_back) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[c] <= new_sum[c];
            quo_ff[c] <= '0;
         end
         iter_ff <= ITER_W'(MEAN_W - 1);
      end else if (cmd.div_step) begin
         for (int c = 0; c < 3; c++) begin
            if ({1'b0, rem_ff[c]} >= dvs) begin
               rem_ff[c] <= SUMW'({1'b0, rem_ff[c]} - dvs);
               quo_ff[c] <= {quo_ff[c][MEAN_W-2:0], 1'b1};
            end else begin
               quo_ff[c] <= {quo_ff[c][MEAN_W-2:0], 1'b0};
            end
         end
         iter_ff <= iter_ff - ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         mean_ff[0] <= quo_ff[0];
         mean_ff[1] <= quo_ff[1];
         mean_ff[2] <= quo_ff[2];
         block_row  <= brow_ff;
         block_col  <= bcol_ff;
         frame_done <= frame_ff;
      end
   end

   assign mean_ch0  = mean_ff[0];
   assign mean_ch1  = mean_ff[1];
   assign mean_ch2  = mean_ff[2];
   assign rsp_valid = out_valid_ff;

   assign sts.block_done = done_ff;
   assign sts.div_last   = (iter_ff == '0);
   assign sts.out_free   = !out_valid_ff || rsp_ready;

endmodule

// File: sim/tb.sv
module tb;
   import bam_pkg::*;

   // One pixel as the driver sends it.
   typedef struct packed {
      logic [PIX_W-1:0] ch0;
      logic [PIX_W-1:0] ch1;
      logic [PIX_W-1:0] ch2;
   } pixel_type;

   // One completed block as the monitor expects it.
   typedef struct packed {
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [MEAN_W-1:0] m0;
      logic [MEAN_W-1:0] m1;
      logic [MEAN_W-1:0] m2;
      logic              done;
   } block_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = REG_SQUARE_SIZE;
   logic [CFG_W-1:0] csr_wdata = '0;

   bam_pixel_if req_if ();
   bam_block_if rsp_if ();

   block_average_mosaic dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always #6 clock = ~clock;

   // Shadow of the block's registers and scan state.
   int unsigned sq_reg, wd_reg, ht_reg;
   int unsigned row_pos, col_pos, band_row, blk_col_off, blk_col;
   int unsigned col_sum [4096][3];

   pixel_type pending_pixels[$];
   block_type expected_blocks[$];
   int        error_count = 0;
   bit        quiet = 1'b0;
   bit        in_fire = 1'b0;
   int        send_gap = 0;
   int        recv_gap = 0;

   function automatic int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Accumulate one pixel and queue the block mean when it closes a block.
   task automatic accumulate_pixel(pixel_type p);
      int unsigned sq, w, h, slot, cnt;
      bit last_col, last_row;
      block_type b;
      sq = clamp(sq_reg, 64);
      w = clamp(wd_reg, 4096);
      h = clamp(ht_reg, 4096);
      slot = (blk_col >= 4096) ? 4095 : blk_col;
      if (band_row == 0 && blk_col_off == 0) begin
         col_sum[slot][0] = p.ch0;
         col_sum[slot][1] = p.ch1;
         col_sum[slot][2] = p.ch2;
      end else begin
         col_sum[slot][0] += p.ch0;
         col_sum[slot][1] += p.ch1;
         col_sum[slot][2] += p.ch2;
      end
      last_col = (col_pos >= w - 1);
      last_row = (row_pos >= h - 1);
      if ((last_col || blk_col_off >= sq - 1) && (last_row || band_row >= sq - 1)) begin
         cnt = (blk_col_off + 1) * (band_row + 1);
         b.row = POS_W'(row_pos / sq);
         b.col = POS_W'(blk_col);
         b.m0 = MEAN_W'(col_sum[slot][0] / cnt);
         b.m1 = MEAN_W'(col_sum[slot][1] / cnt);
         b.m2 = MEAN_W'(col_sum[slot][2] / cnt);
         b.done = last_col && last_row;
         expected_blocks.push_back(b);
      end
      if (last_col) begin
         col_pos = 0;
         blk_col_off = 0;
         blk_col = 0;
         if (last_row) begin
            row_pos = 0;
            band_row = 0;
         end else begin
            row_pos++;
            band_row = (band_row >= sq - 1) ? 0 : band_row + 1;
         end
      end else begin
         col_pos++;
         if (blk_col_off >= sq - 1) begin
            blk_col_off = 0;
            blk_col++;
         end else begin
            blk_col_off++;
         end
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      error_count++;
   endtask

   // Drain everything, then let the last division finish before idle work.
   task automatic wait_idle();
      while (pending_pixels.size() != 0 || expected_blocks.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Write one register while idle; any write restarts the scan.
   task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == REG_SQUARE_SIZE) sq_reg = val & 'h7F;
      else if (idx == REG_IMAGE_WIDTH) wd_reg = val & 'h1FFF;
      else ht_reg = val & 'h1FFF;
      row_pos = 0; col_pos = 0; band_row = 0; blk_col_off = 0; blk_col = 0;
   endtask

   task automatic configure(int unsigned sq, int unsigned w, int unsigned h);
      wait_idle();
      write_reg(REG_SQUARE_SIZE, sq);
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
   endtask

   // Queue pixels; the shadow state follows the order the driver sends them.
   task automatic push_pixel(int unsigned a, int unsigned b, int unsigned c);
      pixel_type p;
      p.ch0 = PIX_W'(a);
      p.ch1 = PIX_W'(b);
      p.ch2 = PIX_W'(c);
      accumulate_pixel(p);
      pending_pixels.push_back(p);
   endtask

   task automatic push_random(int n);
      for (int i = 0; i < n; i++)
         push_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // Record each accepted input transaction at the rising edge.
   always @(posedge clock) begin
      in_fire <= !reset && req_if.valid && req_if.ready;
   end

   // Driver: present the head of the queue, hold it until accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (in_fire)
            void'(pending_pixels.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (!quiet && (!req_if.valid || in_fire) && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(1, 10);
            req_if.valid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            pixel_type p;
            p = pending_pixels[0];
            req_if.valid <= 1'b1;
            req_if.pixel_ch0 <= p.ch0;
            req_if.pixel_ch1 <= p.ch1;
            req_if.pixel_ch2 <= p.ch2;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver stalls come in bursts too; quiet disables them near the end.
   always @(negedge clock) begin
      if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         recv_gap <= $urandom_range(1, 10);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_blocks.size() == 0) begin
            report_mismatch("unexpected block", rsp_if.block_row, -1);
         end else begin
            block_type e;
            e = expected_blocks.pop_front();
            if (rsp_if.block_row !== e.row) report_mismatch("block_row", rsp_if.block_row, e.row);
            if (rsp_if.block_col !== e.col) report_mismatch("block_col", rsp_if.block_col, e.col);
            if (rsp_if.mean_ch0 !== e.m0) report_mismatch("mean_ch0", rsp_if.mean_ch0, e.m0);
            if (rsp_if.mean_ch1 !== e.m1) report_mismatch("mean_ch1", rsp_if.mean_ch1, e.m1);
            if (rsp_if.mean_ch2 !== e.m2) report_mismatch("mean_ch2", rsp_if.mean_ch2, e.m2);
            if (rsp_if.frame_done !== e.done)
               report_mismatch("frame_done", rsp_if.frame_done, e.done);
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.pixel_ch0 = '0;
      req_if.pixel_ch1 = '0;
      req_if.pixel_ch2 = '0;
      rsp_if.ready = 1'b0;
      sq_reg = 8; wd_reg = 640; ht_reg = 480;
      row_pos = 0; col_pos = 0; band_row = 0; blk_col_off = 0; blk_col = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full-scale and zero pixels in 2x2 blocks with clipping.
      configure(2, 3, 3);
      push_pixel(255, 255, 255); push_pixel(255, 255, 255); push_pixel(0, 255, 128);
      push_pixel(255, 255, 255); push_pixel(255, 254, 1); push_pixel(1, 0, 255);
      push_pixel(0, 0, 0); push_pixel(170, 85, 15); push_pixel(255, 0, 240);
      // Pause the sender until every block is back.
      wait_idle();
      // Zero registers read as one: single-pixel blocks, then frame wrap.
      configure(0, 0, 0);
      push_pixel(255, 0, 255); push_pixel(0, 255, 0); push_pixel(255, 255, 255);
      // Oversized square saturates; width 8191 saturates to the maximum.
      configure(127, 5, 2);
      push_random(10);
      configure(64, 8191, 1);
      push_random(6);
      // Register write mid-frame restarts the scan.
      configure(3, 4, 4);
      push_random(5);

      // Random phases, mostly small images and square sizes.
      for (int ph = 0; ph < 16; ph++) begin
         int unsigned sq, w, h;
         sq = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 6);
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
         h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 10);
         configure(sq, w, h);
         if (ph == 15) quiet = 1'b1;
         push_random($urandom_range(30, 70));
      end
      wait_idle();
      if (error_count == 0)
         $display("** block_average_mosaic: PASSED **");
      else
         $display("** block_average_mosaic: FAILED **");
      $finish;
   end

   // Generous limit for about 800 pixels at the slowest stall pattern.
   initial begin
      #(12 * 200000);
      $display("** block_average_mosaic: FAILED **");
      $finish;
   end

endmodule
